@@ design/countdown_timer_with_encoder_set_defines.svh @@
// Assertion macros for the countdown timer with encoder-set preset.
// Used by the port checker; expects a clock named i_clk and reset i_rst_n in scope.
`ifndef COUNTDOWN_TIMER_WITH_ENCODER_SET_DEFINES_SVH
`define COUNTDOWN_TIMER_WITH_ENCODER_SET_DEFINES_SVH

// Same-cycle implication, off while reset is asserted
`define CTWES_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted
`define CTWES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that stays armed through reset
`define CTWES_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ctwes_pkg.sv @@
// Package for the countdown timer with encoder-set preset.
// Holds command codes, register map, shared structs and the mod-5 helper; no dependencies.
`timescale 1ns / 1ps

package ctwes_pkg;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [15:0] STEP_SECONDS   = 16'd5;
    localparam logic [15:0] DOWN_FLOOR     = 16'd4;
    localparam logic [14:0] SPIKE_LIMIT_RST = 15'd50;
    localparam logic [15:0] MAX_SECONDS_RST = 16'd5995;

    // Event codes of an input item
    typedef enum logic [2:0] {
        CMD_SEC_TICK    = 3'd0,
        CMD_BLINK       = 3'd1,
        CMD_START_PAUSE = 3'd2,
        CMD_RESTART     = 3'd3,
        CMD_ENC_SAMPLE  = 3'd4
    } t_cmd;

    // Register indexes (paddr[2])
    localparam logic REG_SPIKE_LIMIT = 1'b0;
    localparam logic REG_MAX_SECONDS = 1'b1;

    typedef struct packed {
        logic [14:0] spike_limit;
        logic [15:0] max_seconds;
    } t_cfg;

    typedef struct packed {
        logic [15:0]        preset;
        logic [15:0]        remaining;
        logic [15:0]        last_pos;
        logic signed [1:0]  acc;
    } t_enc_state;

    // Remainder by 5 of a 16-bit value: 16 = 1 (mod 5), so fold nibbles
    function automatic logic [2:0] mod5(input logic [15:0] v);
        logic [5:0] s;
        logic [4:0] f;
        s = {2'b00, v[3:0]} + {2'b00, v[7:4]} + {2'b00, v[11:8]} + {2'b00, v[15:12]};
        f = {3'b000, s[5:4]} + {1'b0, s[3:0]};
        for (int i = 0; i < 3; i++) begin
            if (f >= 5'd5) begin
                f = f - 5'd5;
            end
        end
        return f[2:0];
    endfunction

endpackage

@@ design/ctwes_ifs.sv @@
// Valid/ready channel interfaces for event items and status items.
// No dependencies.
`timescale 1ns / 1ps

interface ctwes_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic signed [15:0] encoder_position;

    modport source (output valid, output command, output encoder_position, input ready);
    modport sink   (input valid, input command, input encoder_position, output ready);
endinterface

interface ctwes_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] shown_seconds;
    logic        display_on;
    logic        running;
    logic        expired;

    modport source (output valid, output shown_seconds, output display_on,
                    output running, output expired, input ready);
    modport sink   (input valid, input shown_seconds, input display_on,
                    input running, input expired, output ready);
endinterface

@@ design/countdown_timer_with_encoder_set.sv @@
// Countdown timer with encoder-set preset: top level.
// Depends on ctwes_pkg, ctwes_ifs, ctwes_apb_regs and ctwes_core.
//
// Usage:
//   i_cmd_if carries one event item per handshake (second tick, blink tick,
//   start/pause, restart, encoder sample) with the encoder counter value.
//   o_res_if returns exactly one status item per event: remaining seconds,
//   display-on, running and expired.
//   The APB-style port sets the spike limit (address 0) and the preset
//   ceiling (address 4); write only while no item is in flight.
// Timing:
//   An accepted item is held in the input register; its state update and
//   result are registered into the result register once that register is
//   free or being taken, so a stall keeps the item in the input register.
//   One item per cycle is sustained while o_res_if.ready stays high: the
//   whole update is a single pass through the event logic and the encoder step.
// Reset:
//   Synchronous, active low. Timer paused, all counts zero, display on,
//   registers back to spike limit 50 and ceiling 5995. No clearing pass.
// Backpressure:
//   While o_res_if.ready is low the result is held; one more item can be
//   taken into the input register before i_cmd_if.ready drops.
`timescale 1ns / 1ps

module countdown_timer_with_encoder_set (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ctwes_cmd_if.sink                           i_cmd_if,
    ctwes_res_if.source                         o_res_if,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ctwes_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ctwes_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ctwes_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import ctwes_pkg::*;

    t_cfg cfg;

    ctwes_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ctwes_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_cmd_if (i_cmd_if),
        .o_res_if (o_res_if)
    );

endmodule

@@ design/ctwes_apb_regs.sv @@
// APB-style configuration registers: spike limit and preset ceiling.
// Depends on ctwes_pkg.
`timescale 1ns / 1ps

module ctwes_apb_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ctwes_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ctwes_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ctwes_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    output ctwes_pkg::t_cfg                     o_cfg
);
    import ctwes_pkg::*;

    logic        wr_en;
    logic [14:0] r_spike_limit;
    logic [15:0] r_max_seconds;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spike_limit <= SPIKE_LIMIT_RST;
            r_max_seconds <= MAX_SECONDS_RST;
        end else if (wr_en) begin
            if (paddr[2] == REG_SPIKE_LIMIT) begin
                r_spike_limit <= pwdata[14:0];
            end else begin
                r_max_seconds <= pwdata[15:0];
            end
        end
    end

    // Read back the addressed register
    always_comb begin
        if (paddr[2] == REG_MAX_SECONDS) begin
            prdata = {16'd0, r_max_seconds};
        end else begin
            prdata = {17'd0, r_spike_limit};
        end
    end

    assign o_cfg.spike_limit = r_spike_limit;
    assign o_cfg.max_seconds = r_max_seconds;

endmodule

@@ design/ctwes_enc_step.sv @@
// Encoder sample update: glitch filter, detent pairing, saturating 5-second steps.
// Depends on ctwes_pkg.
`timescale 1ns / 1ps

module ctwes_enc_step (
    input  ctwes_pkg::t_cfg         i_cfg,
    input  ctwes_pkg::t_enc_state   i_state,
    input  logic signed [15:0]      i_pos,
    output ctwes_pkg::t_enc_state   o_state
);
    import ctwes_pkg::*;

    logic [15:0]        diff;
    logic signed [16:0] diff_s;
    logic signed [16:0] lim;
    logic signed [16:0] neg_lim;
    logic signed [16:0] move;
    logic signed [16:0] t;
    logic signed [16:0] mag;
    logic               up;
    logic               down;
    logic [14:0]        n_up;
    logic [14:0]        n_dn;
    logic [14:0]        k;
    logic [17:0]        sum_up;
    logic [15:0]        sat_val;
    logic [15:0]        p0;
    logic [16:0]        sub;
    logic [15:0]        dn_val;

    // Wrapped move since the last sample, dropped when it looks like a spike
    assign diff    = $unsigned(i_pos) - i_state.last_pos;
    assign diff_s  = $signed({diff[15], diff});
    assign lim     = $signed({2'b00, i_cfg.spike_limit});
    assign neg_lim = -lim;
    assign move    = ((diff_s > lim) || (diff_s < neg_lim)) ? 17'sd0 : diff_s;

    // Add to the leftover half detent
    assign t    = $signed({{15{i_state.acc[1]}}, i_state.acc}) + move;
    assign up   = (t >= 17'sd2);
    assign down = (t <= -17'sd2);
    assign mag  = -t;
    assign n_up = t[15:1];
    assign n_dn = mag[15:1];

    // Step up: add 5 per step, saturate at the ceiling
    assign sum_up  = {2'b00, i_state.preset} + {1'b0, n_up, 2'b00} + {3'b000, n_up};
    assign sat_val = (sum_up > {2'b00, i_cfg.max_seconds}) ? i_cfg.max_seconds
                                                           : sum_up[15:0];

    // Step down: first step to p0, then as many more as fit, else leave p0 mod 5
    assign p0     = (i_state.preset >= STEP_SECONDS) ? (i_state.preset - STEP_SECONDS) : 16'd0;
    assign k      = n_dn - 15'd1;
    assign sub    = {k, 2'b00} + {2'b00, k};
    assign dn_val = ({1'b0, p0} >= sub) ? (p0 - sub[15:0]) : {13'd0, mod5(p0)};

    always_comb begin
        o_state          = i_state;
        o_state.last_pos = $unsigned(i_pos);
        if (up) begin
            o_state.preset    = sat_val;
            o_state.remaining = sat_val;
            o_state.acc       = {1'b0, t[0]};
        end else if (down) begin
            if (i_state.remaining > DOWN_FLOOR) begin
                o_state.preset    = dn_val;
                o_state.remaining = dn_val;
            end
            o_state.acc = mag[0] ? 2'sb11 : 2'sb00;
        end else begin
            o_state.acc = t[1:0];
        end
    end

endmodule

@@ design/ctwes_core.sv @@
// Timer datapath: input register, state update per event, result register.
// Depends on ctwes_pkg, ctwes_ifs and ctwes_enc_step.
`timescale 1ns / 1ps

module ctwes_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ctwes_pkg::t_cfg  i_cfg,
    ctwes_cmd_if.sink        i_cmd_if,
    ctwes_res_if.source      o_res_if
);
    import ctwes_pkg::*;

    logic               r_in_valid;
    logic [2:0]         r_cmd;
    logic signed [15:0] r_pos;
    logic               advance;
    logic               fire;

    logic               r_run;
    logic               n_run;
    logic               r_lit;
    logic               n_lit;
    t_enc_state         r_enc;
    t_enc_state         n_enc;
    t_enc_state         enc_next;

    logic               r_out_valid;
    logic [15:0]        r_shown;
    logic               r_disp;
    logic               r_running;
    logic               r_expired;

    // Handshake: the input stage moves when the result register is free
    assign advance         = !r_out_valid || o_res_if.ready;
    assign fire            = r_in_valid && advance;
    assign i_cmd_if.ready  = !r_in_valid || advance;

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd_if.ready) begin
            r_in_valid <= i_cmd_if.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_if.valid && i_cmd_if.ready) begin
            r_cmd <= i_cmd_if.command;
            r_pos <= i_cmd_if.encoder_position;
        end
    end

    ctwes_enc_step u_enc_step (
        .i_cfg   (i_cfg),
        .i_state (r_enc),
        .i_pos   (r_pos),
        .o_state (enc_next)
    );

    // Next state for the held event
    always_comb begin
        n_run = r_run;
        n_lit = r_lit;
        n_enc = r_enc;
        case (t_cmd'(r_cmd))
            CMD_SEC_TICK: begin
                if (r_run && (r_enc.remaining != 16'd0)) begin
                    n_enc.remaining = r_enc.remaining - 16'd1;
                end
            end
            CMD_BLINK: begin
                if (!r_run) begin
                    n_lit = !r_lit;
                end
            end
            CMD_START_PAUSE: begin
                n_lit = 1'b1;
                if (r_run) begin
                    n_run          = 1'b0;
                    n_enc.last_pos = $unsigned(r_pos);
                    n_enc.acc      = 2'sb00;
                end else begin
                    n_run = 1'b1;
                end
            end
            CMD_RESTART: begin
                n_enc.remaining = r_enc.preset;
                n_run           = 1'b1;
                n_lit           = 1'b1;
            end
            CMD_ENC_SAMPLE: begin
                if (!r_run) begin
                    n_enc = enc_next;
                end
            end
            default: begin
            end
        endcase
    end

    // Advance timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_lit <= 1'b1;
            r_enc <= '0;
        end else if (fire) begin
            r_run <= n_run;
            r_lit <= n_lit;
            r_enc <= n_enc;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_shown   <= n_enc.remaining;
            r_disp    <= n_lit;
            r_running <= n_run;
            r_expired <= (n_enc.remaining == 16'd0);
        end
    end

    assign o_res_if.valid         = r_out_valid;
    assign o_res_if.shown_seconds = r_shown;
    assign o_res_if.display_on    = r_disp;
    assign o_res_if.running       = r_running;
    assign o_res_if.expired       = r_expired;

endmodule

@@ design/ctwes_checker.sv @@
// Port-level checks on the status channel of the countdown timer.
// Depends on countdown_timer_with_encoder_set_defines.svh; bound to the top level.
`timescale 1ns / 1ps
`include "countdown_timer_with_encoder_set_defines.svh"

module ctwes_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [15:0] i_shown_seconds,
    input logic        i_display_on,
    input logic        i_running,
    input logic        i_expired
);

    // Expired flag tracks the shown count
    `CTWES_ASSERT_SAME(a_expired_flag, i_res_valid, i_expired == (i_shown_seconds == 16'd0), "expired flag does not match shown seconds")

    // A running timer is never blanked
    `CTWES_ASSERT_SAME(a_run_lit, i_res_valid && i_running, i_display_on, "display blanked while running")

    // A stalled result holds
    `CTWES_ASSERT_NEXT(a_stall_hold, i_res_valid && !i_res_ready, i_res_valid && $stable(i_shown_seconds) && $stable(i_running), "stalled result changed")

    // Nothing comes out right after reset
    `CTWES_ASSERT_RST(a_reset_quiet, !i_rst_n, !i_res_valid, "result valid right after reset")

endmodule

bind countdown_timer_with_encoder_set ctwes_checker u_ctwes_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_res_valid     (o_res_if.valid),
    .i_res_ready     (o_res_if.ready),
    .i_shown_seconds (o_res_if.shown_seconds),
    .i_display_on    (o_res_if.display_on),
    .i_running       (o_res_if.running),
    .i_expired       (o_res_if.expired)
);
